@@ rtl/kl_pkg.sv @@
`default_nettype none

package kl_pkg;

    localparam int CodeW = 32;

    // configuration register indexes
    localparam logic [2:0] CFG_DIGITS  = 3'd0;
    localparam logic [2:0] CFG_ATTEMPT = 3'd1;
    localparam logic [2:0] CFG_LOCKOUT = 3'd2;
    localparam logic [2:0] CFG_OPEN    = 3'd3;
    localparam logic [2:0] CFG_HOLD    = 3'd4;
    localparam logic [2:0] CFG_CLOSE   = 3'd5;
    localparam logic [2:0] CFG_SPEED   = 3'd6;

    localparam logic       KIND_BYTE = 1'b0;
    localparam logic       KIND_TICK = 1'b1;

    localparam logic [7:0] REPLY_DIFF  = 8'd0;
    localparam logic [7:0] REPLY_SAME  = 8'd2;
    localparam logic [7:0] REPLY_MATCH = 8'd5;

    localparam logic [7:0] OPT_OPEN  = 8'h2B;  // '+'
    localparam logic [7:0] OPT_RESET = 8'h2D;  // '-'

    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_BWD  = 2'd2;

    typedef enum logic [7:0] {
        MODE_SETUP1  = 8'b0000_0001,
        MODE_SETUP2  = 8'b0000_0010,
        MODE_OPTION  = 8'b0000_0100,
        MODE_ENTRY   = 8'b0000_1000,
        MODE_LOCKOUT = 8'b0001_0000,
        MODE_OPEN    = 8'b0010_0000,
        MODE_HOLD    = 8'b0100_0000,
        MODE_CLOSE   = 8'b1000_0000
    } t_mode;

    typedef struct packed {
        logic [3:0] digits_per_code;
        logic [2:0] attempt_limit;
        logic [7:0] lockout_ticks;
        logic [7:0] open_ticks;
        logic [7:0] hold_ticks;
        logic [7:0] close_ticks;
        logic [7:0] motor_speed;
    } t_cfg;

    typedef struct packed {
        logic       send_valid;
        logic [7:0] send_byte;
        logic [1:0] motor_dir;
        logic [7:0] motor_drive;
        logic       buzzer;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/kl_cfg_regs.sv @@
`default_nettype none

module kl_cfg_regs
    import kl_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_wr,
    input  wire logic [2:0] i_index,
    input  wire logic [7:0] i_data,
    output t_cfg            o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.digits_per_code <= 4'd5;
            r_cfg.attempt_limit   <= 3'd3;
            r_cfg.lockout_ticks   <= 8'd60;
            r_cfg.open_ticks      <= 8'd15;
            r_cfg.hold_ticks      <= 8'd3;
            r_cfg.close_ticks     <= 8'd15;
            r_cfg.motor_speed     <= 8'd200;
        end else if (i_wr) begin
            case (i_index)
                CFG_DIGITS:  r_cfg.digits_per_code <= i_data[3:0];
                CFG_ATTEMPT: r_cfg.attempt_limit   <= i_data[2:0];
                CFG_LOCKOUT: r_cfg.lockout_ticks   <= i_data;
                CFG_OPEN:    r_cfg.open_ticks      <= i_data;
                CFG_HOLD:    r_cfg.hold_ticks      <= i_data;
                CFG_CLOSE:   r_cfg.close_ticks     <= i_data;
                CFG_SPEED:   r_cfg.motor_speed     <= i_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ rtl/kl_fsm.sv @@
`default_nettype none

module kl_fsm
    import kl_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic       i_kind,
    input  wire logic [7:0] i_rx_byte,
    input  t_cfg            i_cfg,
    output t_result         o_result
);

    t_mode              r_mode,        n_mode;
    logic [3:0]         r_digit_count, n_digit_count;
    logic [CodeW-1:0]   r_entry_accum, n_entry_accum;
    logic [CodeW-1:0]   r_first_entry, n_first_entry;
    logic [CodeW-1:0]   r_stored_code;
    logic [2:0]         r_miss_count,  n_miss_count;
    logic [7:0]         r_option_held, n_option_held;
    logic [7:0]         r_tick_count,  n_tick_count;

    logic               store_wr;
    logic [CodeW-1:0]   fold;
    logic [3:0]         cnt_inc;
    logic               code_done;
    logic [2:0]         miss_inc;
    logic [7:0]         tick_inc;
    logic [7:0]         limit;
    logic               timed;
    t_result            res;

    // code*10 + byte as two shifts and two adds
    assign fold = {r_entry_accum[CodeW-4:0], 3'b000}
                + {r_entry_accum[CodeW-2:0], 1'b0}
                + {{(CodeW-8){1'b0}}, i_rx_byte};
    assign cnt_inc   = r_digit_count + 4'd1;
    assign code_done = (cnt_inc >= i_cfg.digits_per_code) || (cnt_inc == 4'd0);
    assign miss_inc  = r_miss_count + 3'd1;
    assign tick_inc  = r_tick_count + 8'd1;

    always_comb begin
        case (r_mode)
            MODE_LOCKOUT: begin limit = i_cfg.lockout_ticks; timed = 1'b1; end
            MODE_OPEN:    begin limit = i_cfg.open_ticks;    timed = 1'b1; end
            MODE_HOLD:    begin limit = i_cfg.hold_ticks;    timed = 1'b1; end
            MODE_CLOSE:   begin limit = i_cfg.close_ticks;   timed = 1'b1; end
            default:      begin limit = 8'd0;                timed = 1'b0; end
        endcase
    end

    always_comb begin
        n_mode        = r_mode;
        n_digit_count = r_digit_count;
        n_entry_accum = r_entry_accum;
        n_first_entry = r_first_entry;
        n_miss_count  = r_miss_count;
        n_option_held = r_option_held;
        n_tick_count  = r_tick_count;
        store_wr      = 1'b0;
        res           = '0;

        if (i_kind == KIND_TICK) begin
            if (timed) begin
                n_tick_count = tick_inc;
                if (tick_inc >= limit) begin
                    n_tick_count = 8'd0;
                    case (r_mode)
                        MODE_OPEN: n_mode = MODE_HOLD;
                        MODE_HOLD: n_mode = MODE_CLOSE;
                        default:   n_mode = MODE_OPTION;
                    endcase
                end
            end
        end else begin
            if (r_mode == MODE_SETUP1 || r_mode == MODE_SETUP2 || r_mode == MODE_ENTRY) begin
                n_entry_accum = code_done ? '0 : fold;
                n_digit_count = code_done ? 4'd0 : cnt_inc;
            end
            case (r_mode)
                MODE_SETUP1: begin
                    if (code_done) begin
                        n_first_entry = fold;
                        n_mode        = MODE_SETUP2;
                    end
                end
                MODE_SETUP2: begin
                    if (code_done) begin
                        res.send_valid = 1'b1;
                        if (fold == r_first_entry) begin
                            res.send_byte = REPLY_SAME;
                            store_wr      = 1'b1;
                            n_mode        = MODE_OPTION;
                        end else begin
                            res.send_byte = REPLY_DIFF;
                            n_mode        = MODE_SETUP1;
                        end
                    end
                end
                MODE_OPTION: begin
                    n_option_held = i_rx_byte;
                    n_miss_count  = 3'd0;
                    n_entry_accum = '0;
                    n_digit_count = 4'd0;
                    n_mode        = MODE_ENTRY;
                end
                MODE_ENTRY: begin
                    if (code_done) begin
                        res.send_valid = 1'b1;
                        if (fold == r_stored_code) begin
                            res.send_byte = REPLY_MATCH;
                            if (r_option_held == OPT_OPEN) begin
                                n_mode       = MODE_OPEN;
                                n_tick_count = 8'd0;
                            end else if (r_option_held == OPT_RESET) begin
                                n_mode = MODE_SETUP1;
                            end else begin
                                n_mode = MODE_OPTION;
                            end
                        end else begin
                            n_miss_count  = miss_inc;
                            res.send_byte = {5'd0, miss_inc};
                            if (miss_inc >= i_cfg.attempt_limit || miss_inc == 3'd0) begin
                                n_mode       = MODE_LOCKOUT;
                                n_tick_count = 8'd0;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        case (n_mode)
            MODE_LOCKOUT: res.buzzer = 1'b1;
            MODE_OPEN: begin
                res.motor_dir   = DIR_FWD;
                res.motor_drive = i_cfg.motor_speed;
            end
            MODE_HOLD:  res.motor_dir = DIR_FWD;
            MODE_CLOSE: begin
                res.motor_dir   = DIR_BWD;
                res.motor_drive = i_cfg.motor_speed;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_SETUP1;
            r_digit_count <= 4'd0;
            r_entry_accum <= '0;
            r_first_entry <= '0;
            r_miss_count  <= 3'd0;
            r_option_held <= 8'd0;
            r_tick_count  <= 8'd0;
        end else if (i_step) begin
            r_mode        <= n_mode;
            r_digit_count <= n_digit_count;
            r_entry_accum <= n_entry_accum;
            r_first_entry <= n_first_entry;
            r_miss_count  <= n_miss_count;
            r_option_held <= n_option_held;
            r_tick_count  <= n_tick_count;
        end
    end

    // written once setup agrees; read only in code entry
    always_ff @(posedge i_clk) begin
        if (i_step && store_wr) begin
            r_stored_code <= fold;
        end
    end

    assign o_result = res;

endmodule

`default_nettype wire

@@ rtl/keypad_lock_controller_top.sv @@
// Channel   Direction  Handshake                   Payload
// in        sink       i_in_valid / o_in_ready     i_kind, i_rx_byte
// out       source     o_out_valid / i_out_ready   o_send_valid, o_send_byte,
//                                                  o_motor_dir, o_motor_drive, o_buzzer
// cfg       sink       i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// Each beat goes from input to result via the input register, then one pass
// through the state update into the result register. One beat per cycle sustained
// while the result is not stalled. While the result is stalled one more beat waits in
// the input register; it moves on in the cycle the result drains.
// Reset is synchronous; state and configuration return to their defaults at once.
// Configuration writes are always taken.
`default_nettype none

module keypad_lock_controller_top
    import kl_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_kind,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic            o_send_valid,
    output logic [7:0]      o_send_byte,
    output logic [1:0]      o_motor_dir,
    output logic [7:0]      o_motor_drive,
    output logic            o_buzzer,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);

    logic       r_in_valid;
    logic       r_kind;
    logic [7:0] r_rx_byte;
    logic       r_out_valid;
    t_result    r_out;
    t_result    step_res;
    t_cfg       cfg;
    logic       advance;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    kl_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    kl_fsm u_fsm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_kind    (r_kind),
        .i_rx_byte (r_rx_byte),
        .i_cfg     (cfg),
        .o_result  (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_kind    <= i_kind;
            r_rx_byte <= i_rx_byte;
        end
        if (advance) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_send_valid  = r_out.send_valid;
    assign o_send_byte   = r_out.send_byte;
    assign o_motor_dir   = r_out.motor_dir;
    assign o_motor_drive = r_out.motor_drive;
    assign o_buzzer      = r_out.buzzer;

endmodule

`default_nettype wire

@@ rtl/kl_checker.sv @@
`default_nettype none

module kl_checker
    import kl_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic       o_send_valid,
    input wire logic [7:0] o_send_byte,
    input wire logic [1:0] o_motor_dir,
    input wire logic [7:0] o_motor_drive,
    input wire logic       o_buzzer
);

    a_no_reply_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_send_valid |-> o_send_byte == REPLY_DIFF)
        else $error("reply byte set without send_valid");

    a_buzz_motor_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_buzzer |-> o_motor_dir == DIR_STOP && o_motor_drive == 8'd0)
        else $error("motor active during lockout");

    a_stop_no_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_motor_dir == DIR_STOP |-> o_motor_drive == 8'd0)
        else $error("drive while stopped");

    a_dir_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_motor_dir == DIR_STOP || o_motor_dir == DIR_FWD
                        || o_motor_dir == DIR_BWD)
        else $error("illegal motor direction");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_send_byte)
                                        && $stable(o_motor_drive))
        else $error("stalled beat changed");

endmodule

bind keypad_lock_controller_top kl_checker u_kl_checker (.*);

`default_nettype wire
